@@ rtl/wfmt_pkg.sv @@
// ============================================================================
// Wildcard first-match table: shared package
// Field widths, default sizes, the operation and state codes, and the structs
// for the write command sent to every cell and the lookup word on the chain.
// ============================================================================
package wfmt_pkg;

    localparam int DEF_ENTRIES     = 32;
    localparam int DEF_KEY_FIELDS  = 4;
    localparam int DEF_FIELD_WIDTH = 16;

    // Fixed widths of the words on the ports.
    localparam int KEY_INPUTS = 4;
    localparam int KEY_IN_W   = 16;
    localparam int INDEX_W    = 5;
    localparam int VALUE_W    = 16;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    // Lookup word state that travels from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } tok_t;

    // Write command broadcast to every cell.
    typedef struct packed {
        logic                  en;
        logic [INDEX_W-1:0]    index;
        logic [KEY_INPUTS-1:0] mask;
        logic [VALUE_W-1:0]    value;
        logic                  enable;
    } wr_t;

endpackage

@@ rtl/wfmt_if.sv @@
// ============================================================================
// Wildcard first-match table: channel interfaces
// Valid/ready channels for the incoming command word and the result word.
// ============================================================================
interface wfmt_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic [wfmt_pkg::INDEX_W-1:0]          entry_index;
    logic [wfmt_pkg::KEY_IN_W-1:0]         key0;
    logic [wfmt_pkg::KEY_IN_W-1:0]         key1;
    logic [wfmt_pkg::KEY_IN_W-1:0]         key2;
    logic [wfmt_pkg::KEY_IN_W-1:0]         key3;
    logic [wfmt_pkg::KEY_INPUTS-1:0]       wildcard_mask;
    logic [wfmt_pkg::VALUE_W-1:0]          entry_value;
    logic                                  entry_enable;

    modport source (
        output valid, operation, entry_index, key0, key1, key2, key3,
               wildcard_mask, entry_value, entry_enable,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, key0, key1, key2, key3,
               wildcard_mask, entry_value, entry_enable,
        output ready
    );
endinterface

interface wfmt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [wfmt_pkg::VALUE_W-1:0]  result_value;
    logic [wfmt_pkg::INDEX_W-1:0]  match_index;

    modport source (output valid, found, result_value, match_index, input ready);
    modport sink   (input  valid, found, result_value, match_index, output ready);
endinterface

@@ rtl/wfmt_cell.sv @@
// ============================================================================
// Wildcard first-match table: table cell
// Holds one table entry and compares it against the lookup word passing by.
// The first cell that hits marks the word as found; later cells leave it.
// ============================================================================
module wfmt_cell #(
    parameter int FIELD_WIDTH = 16,
    parameter int NUM_F       = 4,
    parameter int CELL_INDEX  = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  wfmt_pkg::wr_t                          wr,
    input  logic [NUM_F-1:0][FIELD_WIDTH-1:0]      wr_key,
    input  logic                                   advance,
    input  wfmt_pkg::tok_t                         tok_in,
    input  logic [NUM_F-1:0][FIELD_WIDTH-1:0]      key_in,
    output wfmt_pkg::tok_t                         tok_out,
    output logic [NUM_F-1:0][FIELD_WIDTH-1:0]      key_out
);
    import wfmt_pkg::*;

    logic                                entry_valid_reg;
    logic [NUM_F-1:0][FIELD_WIDTH-1:0]   entry_key_reg;
    logic [NUM_F-1:0]                    entry_mask_reg;
    logic [VALUE_W-1:0]                  entry_value_reg;

    tok_t                                tok_reg;
    tok_t                                tok_next;
    logic [NUM_F-1:0][FIELD_WIDTH-1:0]   key_reg;

    logic                                wr_hit;
    logic                                hit;

    assign wr_hit = wr.en && (int'(wr.index) == CELL_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (wr_hit)
        begin
            entry_valid_reg <= wr.enable;
        end
    end

    // Keys, mask and value are stored even when the entry is being removed.
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            entry_key_reg   <= wr_key;
            entry_mask_reg  <= wr.mask[NUM_F-1:0];
            entry_value_reg <= wr.value;
        end
    end

    always_comb
    begin
        hit = entry_valid_reg;
        for (int f = 0; f < NUM_F; f++)
        begin
            if (!entry_mask_reg[f] && (entry_key_reg[f] != key_in[f]))
            begin
                hit = 1'b0;
            end
        end

        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && hit)
        begin
            tok_next.found = 1'b1;
            tok_next.value = entry_value_reg;
            tok_next.index = INDEX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_in;
        end
    end

    assign tok_out = tok_reg;
    assign key_out = key_reg;

endmodule

@@ rtl/wildcard_first_match_table_core.sv @@
// ============================================================================
// Wildcard first-match table: top level
// A row of table cells; lookups walk the row, writes go straight to a cell.
// ============================================================================
// A write word stores or removes the entry at entry_index and its result word
// (found clear, all zero) is registered in the cycle after acceptance. A lookup
// word enters the first cell and moves one cell per cycle, while the row is not
// frozen, down the row of ENTRIES cells, each cell comparing it against the
// entry it holds; the lowest-index hit is kept, and the result word is
// registered as the lookup word leaves the last cell.
// The block takes one word at a time: a new word is accepted only when no
// lookup is in the row and the result register is empty or is being read in
// the same cycle. A result word that waits unread therefore holds off the
// next word.
// Valid marks are cleared by reset; entry contents are undefined until written.
module wildcard_first_match_table_core #(
    parameter int ENTRIES     = wfmt_pkg::DEF_ENTRIES,
    parameter int KEY_FIELDS  = wfmt_pkg::DEF_KEY_FIELDS,
    parameter int FIELD_WIDTH = wfmt_pkg::DEF_FIELD_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    wfmt_in_if.sink    in_word,
    wfmt_out_if.source out_word
);
    import wfmt_pkg::*;

    // Only the four key inputs can take part in matching.
    localparam int NUM_F = (KEY_FIELDS < KEY_INPUTS) ? KEY_FIELDS : KEY_INPUTS;

    state_t                               state_reg;
    state_t                               state_next;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 out_found_reg;
    logic                                 out_found_next;
    logic [VALUE_W-1:0]                   out_value_reg;
    logic [VALUE_W-1:0]                   out_value_next;
    logic [INDEX_W-1:0]                   out_index_reg;
    logic [INDEX_W-1:0]                   out_index_next;

    logic                                 in_fire;
    logic                                 is_write;
    logic                                 advance;
    logic                                 tail_done;

    logic [KEY_INPUTS-1:0][KEY_IN_W-1:0]  raw_key;
    logic [NUM_F-1:0][FIELD_WIDTH-1:0]    key_word;
    wr_t                                  wr;

    tok_t                                 head_tok;
    tok_t                                 tok_chain [ENTRIES+1];
    logic [NUM_F-1:0][FIELD_WIDTH-1:0]    key_chain [ENTRIES+1];
    tok_t                                 tail_tok;

    assign in_fire  = in_word.valid && in_word.ready;
    assign is_write = (in_word.operation == OP_WRITE);

    assign raw_key = {in_word.key3, in_word.key2, in_word.key1, in_word.key0};

    always_comb
    begin
        for (int f = 0; f < NUM_F; f++)
        begin
            key_word[f] = FIELD_WIDTH'(raw_key[f]);
        end
    end

    always_comb
    begin
        wr.en     = in_fire && is_write;
        wr.index  = in_word.entry_index;
        wr.mask   = in_word.wildcard_mask;
        wr.value  = in_word.entry_value;
        wr.enable = in_word.entry_enable;
    end

    always_comb
    begin
        head_tok       = '0;
        head_tok.valid = in_fire && !is_write;
    end

    assign tok_chain[0] = head_tok;
    assign key_chain[0] = key_word;

    assign tail_tok  = tok_chain[ENTRIES];
    // The row freezes only while a finished lookup waits for the result slot.
    assign advance   = !(tail_tok.valid && out_valid_reg && !out_word.ready);
    assign tail_done = tail_tok.valid && advance;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        wfmt_cell #(
            .FIELD_WIDTH (FIELD_WIDTH),
            .NUM_F       (NUM_F),
            .CELL_INDEX  (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .wr_key  (key_word),
            .advance (advance),
            .tok_in  (tok_chain[i]),
            .key_in  (key_chain[i]),
            .tok_out (tok_chain[i+1]),
            .key_out (key_chain[i+1])
        );
    end

    assign in_word.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_word.ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_word.ready;
        out_found_next = out_found_reg;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_write)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = 1'b0;
                        out_value_next = '0;
                        out_index_next = '0;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tail_done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_found_next = tail_tok.found;
                    out_value_next = tail_tok.value;
                    out_index_next = tail_tok.index;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
    end

    assign out_word.valid        = out_valid_reg;
    assign out_word.found        = out_found_reg;
    assign out_word.result_value = out_value_reg;
    assign out_word.match_index  = out_index_reg;

    // A lookup word can only be in the row while a search is under way.
    a_tail_only_searching: assert property (@(posedge clk) disable iff (!rst_n)
        tail_tok.valid |-> (state_reg == ST_SEARCH))
        else $error("lookup word at end of row outside a search");

    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_write) |=> (out_valid_reg && !out_found_reg))
        else $error("write word did not produce a cleared result");

    a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_write) |=> (state_reg == ST_SEARCH))
        else $error("lookup word did not start a search");

    a_found_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        tail_done |=> out_valid_reg)
        else $error("finished lookup lost before the result register");

endmodule

@@ tb/wildcard_first_match_table_core_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Wildcard first-match table: testbench
// Writes, removes and looks up table entries through the valid/ready channels
// and predicts every result word from a private copy of the table, then
// compares each accepted result word field by field. A directed opening covers
// the key and value extremes, each wildcard bit and entry priority. Random
// words follow, with random idling on both channels.
// ============================================================================
module wildcard_first_match_table_core_tb;
    import wfmt_pkg::*;

    localparam int TABLE_SLOTS  = DEF_ENTRIES;
    localparam int MATCH_FIELDS = DEF_KEY_FIELDS;
    localparam int POOL_DEPTH   = 6;
    localparam int PHASE_WORDS  = 175;
    localparam int TAIL_CYCLES  = 2 * DEF_ENTRIES + 8;
    localparam int QUIET_LIMIT  = 1000;

    typedef logic [KEY_INPUTS-1:0][KEY_IN_W-1:0] key_vec_t;

    typedef struct packed {
        op_t                   operation;
        logic [INDEX_W-1:0]    entry_index;
        key_vec_t              key;
        logic [KEY_INPUTS-1:0] wildcard_mask;
        logic [VALUE_W-1:0]    entry_value;
        logic                  entry_enable;
    } table_cmd_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } lookup_result_t;

    // Private copy of the table and the queue of result words still owed.
    class match_table_scoreboard;
        key_vec_t              slot_keys  [TABLE_SLOTS];
        logic [KEY_INPUTS-1:0] slot_wild  [TABLE_SLOTS];
        logic [VALUE_W-1:0]    slot_value [TABLE_SLOTS];
        bit                    slot_valid [TABLE_SLOTS];
        lookup_result_t        owed_results[$];
        int                    errors;

        function new();
            errors = 0;
            for (int s = 0; s < TABLE_SLOTS; s++)
            begin
                slot_keys[s]  = '0;
                slot_wild[s]  = '0;
                slot_value[s] = '0;
                slot_valid[s] = 1'b0;
            end
        endfunction

        function bit slot_hits(int s, key_vec_t key);
            for (int f = 0; f < MATCH_FIELDS; f++)
                if (!slot_wild[s][f] && slot_keys[s][f] != key[f])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_input(table_cmd_t c);
            lookup_result_t r;
            r = '0;
            if (c.operation == OP_WRITE)
            begin
                // A removal still overwrites the stored contents.
                slot_keys[c.entry_index]  = c.key;
                slot_wild[c.entry_index]  = c.wildcard_mask;
                slot_value[c.entry_index] = c.entry_value;
                slot_valid[c.entry_index] = c.entry_enable;
            end
            else
            begin
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    if (slot_valid[s] && slot_hits(s, c.key))
                    begin
                        r.found = 1'b1;
                        r.value = slot_value[s];
                        r.index = s[INDEX_W-1:0];
                        break;
                    end
                end
            end
            owed_results.push_back(r);
        endfunction

        function void check_result(logic found, logic [VALUE_W-1:0] value,
                                   logic [INDEX_W-1:0] index);
            lookup_result_t exp_r;
            if (owed_results.size() == 0)
            begin
                $error("result word with none expected: found %0d value %0h index %0d",
                       found, value, index);
                errors++;
                return;
            end
            exp_r = owed_results.pop_front();
            if (found !== exp_r.found)
            begin
                $error("found: expected %0d, got %0d", exp_r.found, found);
                errors++;
            end
            if (value !== exp_r.value)
            begin
                $error("result_value: expected %0h, got %0h", exp_r.value, value);
                errors++;
            end
            if (index !== exp_r.index)
            begin
                $error("match_index: expected %0d, got %0d", exp_r.index, index);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wfmt_in_if  in_bus ();
    wfmt_out_if out_bus ();

    wildcard_first_match_table_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_bus),
        .out_word (out_bus)
    );

    match_table_scoreboard table_sb = new();

    int gap_pct;
    int stall_pct;
    int quiet_cycles;
    logic [KEY_IN_W-1:0] key_pool [KEY_INPUTS][POOL_DEPTH];

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Result side: ready drops in random bursts while stall_pct is nonzero.
    initial
    begin
        out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                out_bus.ready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
            begin
                out_bus.ready = 1'b1;
            end
        end
    end

    // Result checking and the watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_bus.valid && out_bus.ready)
                table_sb.check_result(out_bus.found, out_bus.result_value,
                                      out_bus.match_index);
            if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: %0d cycles without a handshake", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic key_vec_t keys4(logic [KEY_IN_W-1:0] k0, logic [KEY_IN_W-1:0] k1,
                                       logic [KEY_IN_W-1:0] k2, logic [KEY_IN_W-1:0] k3);
        return {k3, k2, k1, k0};
    endfunction

    function automatic table_cmd_t make_write(int idx, key_vec_t key,
                                              logic [KEY_INPUTS-1:0] mask,
                                              logic [VALUE_W-1:0] value, logic enable);
        table_cmd_t c;
        c.operation     = OP_WRITE;
        c.entry_index   = idx[INDEX_W-1:0];
        c.key           = key;
        c.wildcard_mask = mask;
        c.entry_value   = value;
        c.entry_enable  = enable;
        return c;
    endfunction

    // Fields that a lookup ignores carry random junk.
    function automatic table_cmd_t make_lookup(key_vec_t key);
        table_cmd_t c;
        c.operation     = OP_LOOKUP;
        c.entry_index   = INDEX_W'($urandom);
        c.key           = key;
        c.wildcard_mask = KEY_INPUTS'($urandom);
        c.entry_value   = VALUE_W'($urandom);
        c.entry_enable  = 1'($urandom);
        return c;
    endfunction

    function automatic logic [KEY_IN_W-1:0] field_value(int f);
        if ($urandom_range(0, 99) < 85)
            return key_pool[f][$urandom_range(0, POOL_DEPTH - 1)];
        return KEY_IN_W'($urandom);
    endfunction

    function automatic key_vec_t pool_key();
        key_vec_t k;
        for (int f = 0; f < KEY_INPUTS; f++)
            k[f] = field_value(f);
        return k;
    endfunction

    function automatic table_cmd_t random_write();
        logic [KEY_INPUTS-1:0] mask;
        mask = ($urandom_range(0, 99) < 30) ? '0 : KEY_INPUTS'($urandom);
        return make_write($urandom_range(0, TABLE_SLOTS - 1), pool_key(), mask,
                          VALUE_W'($urandom), $urandom_range(0, 99) < 80);
    endfunction

    // Most lookups are aimed at a live entry so that priority gets exercised.
    function automatic table_cmd_t random_lookup();
        int pick;
        int start;
        int s;
        key_vec_t k;
        pick  = $urandom_range(0, 99);
        start = $urandom_range(0, TABLE_SLOTS - 1);
        if (pick < 55)
        begin
            for (int n = 0; n < TABLE_SLOTS; n++)
            begin
                s = (start + n) % TABLE_SLOTS;
                if (table_sb.slot_valid[s])
                begin
                    k = table_sb.slot_keys[s];
                    for (int f = 0; f < KEY_INPUTS; f++)
                        if (table_sb.slot_wild[s][f])
                            k[f] = field_value(f);
                    return make_lookup(k);
                end
            end
        end
        if (pick < 85)
            return make_lookup(pool_key());
        return make_lookup(key_vec_t'({$urandom, $urandom}));
    endfunction

    task automatic send_word(table_cmd_t c);
        @(negedge clk);
        in_bus.valid         = 1'b1;
        in_bus.operation     = c.operation;
        in_bus.entry_index   = c.entry_index;
        in_bus.key0          = c.key[0];
        in_bus.key1          = c.key[1];
        in_bus.key2          = c.key[2];
        in_bus.key3          = c.key[3];
        in_bus.wildcard_mask = c.wildcard_mask;
        in_bus.entry_value   = c.entry_value;
        in_bus.entry_enable  = c.entry_enable;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        table_sb.note_input(c);
    endtask

    task automatic idle_input(int cycles);
        @(negedge clk);
        in_bus.valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_bus.valid = 1'b0;
        while (table_sb.owed_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_paced(table_cmd_t c);
        if ($urandom_range(0, 99) < gap_pct)
            idle_input($urandom_range(1, 6));
        send_word(c);
    endtask

    initial
    begin : stimulus
        key_vec_t tmpl;
        key_vec_t probe;

        quiet_cycles         = 0;
        gap_pct              = 25;
        stall_pct            = 25;
        rst_n                = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.operation     = OP_LOOKUP;
        in_bus.entry_index   = '0;
        in_bus.key0          = '0;
        in_bus.key1          = '0;
        in_bus.key2          = '0;
        in_bus.key3          = '0;
        in_bus.wildcard_mask = '0;
        in_bus.entry_value   = '0;
        in_bus.entry_enable  = 1'b0;

        for (int f = 0; f < KEY_INPUTS; f++)
        begin
            key_pool[f][0] = '0;
            key_pool[f][1] = '1;
            for (int p = 2; p < POOL_DEPTH; p++)
                key_pool[f][p] = KEY_IN_W'($urandom);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: every lookup misses, whatever the key.
        send_paced(make_lookup('0));
        send_paced(make_lookup('1));
        // Key and value extremes at both ends of the table.
        send_paced(make_write(TABLE_SLOTS - 1, '1, '0, '1, 1'b1));
        send_paced(make_lookup('1));
        send_paced(make_write(0, '0, '0, '0, 1'b1));
        send_paced(make_lookup('0));
        // An all-wildcard entry catches everything above it in index.
        send_paced(make_write(5, keys4(16'h0001, 16'h0002, 16'h0003, 16'h0004), '1,
                              16'h1234, 1'b1));
        send_paced(make_lookup('1));
        send_paced(make_lookup(key_vec_t'({$urandom, $urandom})));
        // Removal stores new contents but the entry no longer matches.
        send_paced(make_write(5, '1, '1, 16'hBEEF, 1'b0));
        send_paced(make_lookup('1));
        send_paced(make_write(3, keys4(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 4'b0101,
                              16'hA5A5, 1'b1));
        send_paced(make_lookup(keys4(16'h0000, 16'h5555, 16'h0001, 16'h5555)));
        send_paced(make_lookup(keys4(16'h0000, 16'h5554, 16'h0001, 16'h5555)));
        // One wildcard bit per entry; each probe differs only in that field.
        tmpl = keys4(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        for (int f = 0; f < KEY_INPUTS; f++)
        begin
            send_paced(make_write(8 + f, tmpl, KEY_INPUTS'(1 << f), VALUE_W'(16'h0100 + f),
                                  1'b1));
            probe    = tmpl;
            probe[f] = ~tmpl[f];
            send_paced(make_lookup(probe));
        end
        send_paced(make_lookup(tmpl));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin gap_pct = 20; stall_pct = 20; end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            // Hold off once until every owed result word has come back.
            if (phase == 2)
                drain_results();
            repeat (PHASE_WORDS)
            begin
                if ($urandom_range(0, 99) < 35)
                    send_paced(random_write());
                else
                    send_paced(random_lookup());
            end
        end

        @(negedge clk);
        in_bus.valid = 1'b0;
        while (table_sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (table_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
